// File: sv/c_syntax_highlight_classifier_top_assert.svh
// Assertion macros shared by the RTL of the syntax highlight classifier.
`ifndef C_SYNTAX_HIGHLIGHT_CLASSIFIER_TOP_ASSERT_SVH
`define C_SYNTAX_HIGHLIGHT_CLASSIFIER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSHL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("classifier check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("classifier check failed");

`endif

// File: sv/cshl_pkg.sv
// ----------------------------------------------------------------------------
// cshl_pkg
// Types, constants and the symbol lookup of the syntax highlight classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package cshl_pkg;

   typedef enum logic [2:0] {
      CL_PLAIN  = 3'd0,
      CL_BLOCK  = 3'd1,
      CL_LINE   = 3'd2,
      CL_DSTR   = 3'd3,
      CL_SSTR   = 3'd4,
      CL_DIGIT  = 3'd5,
      CL_SYMBOL = 3'd6
   } class_type;

   localparam int unsigned CharWidth  = 8;
   localparam int unsigned ClassWidth = 3;
   localparam int unsigned ReqDataWidth = 2 * CharWidth;
   localparam int unsigned RspDataWidth = 8;

   localparam logic [CharWidth-1:0] ChSlash     = 8'h2F;
   localparam logic [CharWidth-1:0] ChStar      = 8'h2A;
   localparam logic [CharWidth-1:0] ChDquote    = 8'h22;
   localparam logic [CharWidth-1:0] ChSquote    = 8'h27;
   localparam logic [CharWidth-1:0] ChBackslash = 8'h5C;
   localparam logic [CharWidth-1:0] ChNewline   = 8'h0A;
   localparam logic [CharWidth-1:0] ChZero      = 8'h30;
   localparam logic [CharWidth-1:0] ChNine      = 8'h39;

   // Punctuation set; the pound sign appears as its two UTF-8 bytes.
   function automatic logic is_punct_char(input logic [CharWidth-1:0] c);
      logic hit;
      hit = 1'b0;
      case (c) inside
         8'h7B, 8'h7D, 8'h5B, 8'h5D, 8'h28, 8'h29, 8'h21, 8'h27,
         8'hC2, 8'hA3, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2D,
         8'h2B, 8'h3D, 8'h3A, 8'h3B, 8'h40, 8'h7E, 8'h23, 8'h3C,
         8'h3E, 8'h2C, 8'h2E, 8'h3F, 8'h2F, 8'h5C, 8'h7C: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

endpackage

`default_nettype wire

// File: sv/c_syntax_highlight_classifier_top.sv
// ----------------------------------------------------------------------------
// c_syntax_highlight_classifier_top
// Classifies a stream of C source bytes into highlight classes.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the req_ channel carries one text byte and the byte
//   that follows it as lookahead; req_tuser marks a restart, which returns
//   the lexer to plain mode before that byte is handled. Each request gives
//   exactly one rsp_ transaction holding the byte's class (plain, block
//   comment, line comment, double string, single string, digit or symbol).
//   A request is first captured in the input register; the classification
//   and lexer state update then happen as the item moves into the result
//   register, which drives rsp_tvalid. Throughput is one byte per cycle
//   while rsp_tready is high; the lexer state update is a single level
//   of decode between the two registers.
//   Reset clears both registers' valid flags and puts the lexer in plain
//   mode with no pending skip. When the receiver holds rsp_tready low, the
//   result register holds, the input register fills, and req_tready drops
//   until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module c_syntax_highlight_classifier_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [cshl_pkg::ReqDataWidth-1:0]   req_tdata,  // cur_char, next_char
   input  wire logic                                req_tuser,  // restart
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [cshl_pkg::RspDataWidth-1:0]        rsp_tdata   // char_class, zero pad
);
   import cshl_pkg::*;

   `include "c_syntax_highlight_classifier_top_assert.svh"

   // Input register.
   logic                 in_valid_ff, in_valid_in;
   logic [CharWidth-1:0] cur_ff, cur_in;
   logic [CharWidth-1:0] nxt_ff, nxt_in;
   logic                 restart_ff, restart_in;

   // Result register.
   logic                 out_valid_ff, out_valid_in;
   class_type            out_class_ff, out_class_in;

   // Lexer state.
   class_type            mode_ff, mode_in;
   logic                 skip_ff, skip_in;
   class_type            last_ff, last_in;

   logic      advance;
   class_type mode_eff;
   logic      skip_eff;
   class_type last_eff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-ClassWidth){1'b0}}, out_class_ff};

   always_comb begin
      in_valid_in = in_valid_ff;
      cur_in      = cur_ff;
      nxt_in      = nxt_ff;
      restart_in  = restart_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         cur_in      = req_tdata[CharWidth-1:0];
         nxt_in      = req_tdata[2*CharWidth-1:CharWidth];
         restart_in  = req_tuser;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      mode_eff = restart_ff ? CL_PLAIN : mode_ff;
      skip_eff = restart_ff ? 1'b0     : skip_ff;
      last_eff = restart_ff ? CL_PLAIN : last_ff;

      mode_in      = mode_ff;
      skip_in      = skip_ff;
      last_in      = last_ff;
      out_class_in = out_class_ff;
      out_valid_in = out_valid_ff;

      if (out_valid_ff && rsp_tready) begin
         out_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         mode_in      = mode_eff;
         skip_in      = 1'b0;
         last_in      = last_eff;
         if (skip_eff) begin
            // The byte after a two-character token or an escape repeats.
            out_class_in = last_eff;
         end else begin
            last_in = mode_eff;
            unique case (mode_eff) inside
               CL_PLAIN: begin
                  if (cur_ff == ChSlash && nxt_ff == ChStar) begin
                     skip_in = 1'b1; mode_in = CL_BLOCK;
                     last_in = CL_BLOCK; out_class_in = CL_BLOCK;
                  end else if (cur_ff == ChSlash && nxt_ff == ChSlash) begin
                     skip_in = 1'b1; mode_in = CL_LINE;
                     last_in = CL_LINE; out_class_in = CL_LINE;
                  end else if (cur_ff == ChDquote) begin
                     mode_in = CL_DSTR; out_class_in = CL_DSTR;
                  end else if (cur_ff == ChSquote) begin
                     mode_in = CL_SSTR; out_class_in = CL_SSTR;
                  end else if (cur_ff >= ChZero && cur_ff <= ChNine) begin
                     last_in = CL_DIGIT; out_class_in = CL_DIGIT;
                  end else if (is_punct_char(cur_ff)) begin
                     last_in = CL_SYMBOL; out_class_in = CL_SYMBOL;
                  end else begin
                     out_class_in = CL_PLAIN;
                  end
               end
               CL_BLOCK: begin
                  if (cur_ff == ChStar && nxt_ff == ChSlash) begin
                     skip_in = 1'b1; mode_in = CL_PLAIN;
                  end
                  out_class_in = CL_BLOCK;
               end
               CL_LINE: begin
                  if (cur_ff == ChNewline) begin
                     mode_in = CL_PLAIN; out_class_in = CL_PLAIN;
                  end else begin
                     out_class_in = CL_LINE;
                  end
               end
               CL_DSTR, CL_SSTR: begin
                  if (cur_ff == ChBackslash) begin
                     skip_in = 1'b1;
                  end else if ((mode_eff == CL_DSTR && cur_ff == ChDquote) ||
                               (mode_eff == CL_SSTR && cur_ff == ChSquote)) begin
                     mode_in = CL_PLAIN;
                  end
                  out_class_in = mode_eff;
               end
               default: begin
                  mode_in = CL_PLAIN; last_in = CL_PLAIN; out_class_in = CL_PLAIN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         mode_ff      <= CL_PLAIN;
         skip_ff      <= 1'b0;
         last_ff      <= CL_PLAIN;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         mode_ff      <= mode_in;
         skip_ff      <= skip_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      nxt_ff       <= nxt_in;
      restart_ff   <= restart_in;
      out_class_ff <= out_class_in;
   end

   // A skip consumes exactly one byte unless a restart drops it first.
   `CSHL_ASSERT_NEXT(a_skip_one_byte, clock, reset, advance && skip_ff && !restart_ff, !skip_ff)
   // A held result is not lost while the receiver stalls.
   `CSHL_ASSERT_NEXT(a_rsp_held, clock, reset, out_valid_ff && !rsp_tready, out_valid_ff)
   // A skip in plain mode only follows a block comment closer.
   `CSHL_ASSERT_SAME(a_plain_skip, clock, reset,
                     skip_ff && mode_ff == CL_PLAIN, last_ff == CL_BLOCK)
   // A skip in line comment mode only follows the line comment opener.
   `CSHL_ASSERT_SAME(a_line_skip, clock, reset,
                     skip_ff && mode_ff == CL_LINE, last_ff == CL_LINE)

endmodule

`default_nettype wire
